// ===== src/assert_macros.svh =====
// Assertion helper macros for the RTL files (included by the engine core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/smsp_pkg.sv =====
// ----------------------------------------------------------------------------
// smsp_pkg
// Shared types and constants for the stepdown max-statistic p-value engine.
// ----------------------------------------------------------------------------
package smsp_pkg;

    localparam int DEF_MAX_HYPOTHESES = 16;
    localparam int DEF_MAX_DRAWS      = 1024;
    localparam int DEF_STAT_BITS      = 24;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 11;

    localparam logic [CFG_IDX_BITS-1:0] REG_HYP_COUNT  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DRAW_COUNT = 1'd1;

    localparam logic OP_OBSERVED  = 1'b0;
    localparam logic OP_BOOTSTRAP = 1'b1;

    // Input request fields.
    typedef struct packed {
        logic        op;
        logic [3:0]  hyp_index;
        logic [9:0]  draw_index;
        logic [23:0] stat_value;
        logic        last_load;
    } in_req_t;

    // Result request fields.
    typedef struct packed {
        logic [3:0]  out_hyp;
        logic [10:0] adj_numerator;
        logic        out_last;
    } out_req_t;

endpackage

// ===== src/smsp_ram.sv =====
// ----------------------------------------------------------------------------
// smsp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smsp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/stepdown_max_stat_pvalue_engine_core.sv =====
// ----------------------------------------------------------------------------
// stepdown_max_stat_pvalue_engine_core
// Ranks hypotheses by observed statistic, walks bootstrap draws over the
// ranked suffix maxima and emits stepdown adjusted p-value numerators.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   in        input      in_valid/in_stall    in_req_t
//   out       output     out_valid/out_stall  out_req_t
//   cfg       input      cfg_we               cfg_index, cfg_data
//
// Load requests are accepted only while idle. A last load starts compute: a
// sort with a setup step per hypothesis plus up to H*(H+1)/2 compare steps
// over the observed RAM, then D*H draw steps through the replicate RAM read
// port, then a prefix max along rank order and H result requests. Reset
// clears control state only; stores are undefined until written. A stalled
// result holds.
// ----------------------------------------------------------------------------
module stepdown_max_stat_pvalue_engine_core
    import smsp_pkg::*;
#(
    parameter int MAX_HYPOTHESES = DEF_MAX_HYPOTHESES,
    parameter int MAX_DRAWS      = DEF_MAX_DRAWS,
    parameter int STAT_BITS      = DEF_STAT_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  in_req_t                  in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_req_t                 out_data,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int HB = $clog2(MAX_HYPOTHESES);
    localparam int DB = (MAX_DRAWS > 1) ? $clog2(MAX_DRAWS) : 1;
    localparam int CB = $clog2(MAX_DRAWS + 2);
    localparam int RAB = HB + DB;
    localparam logic [STAT_BITS-1:0] STAT_MAX = {STAT_BITS{1'b1}};

    localparam logic [3:0] S_IDLE = 4'd0, S_SRD = 4'd1, S_SCMP = 4'd2,
                           S_BRD = 4'd3, S_BCMP = 4'd4, S_ACC = 4'd5,
                           S_OUT = 4'd6, S_SINIT = 4'd7;

    logic [3:0] state_reg, state_next;
    logic [4:0]  hcfg_reg;
    logic [10:0] dcfg_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcfg_reg <= 5'd16;
            dcfg_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HYP_COUNT:  hcfg_reg <= cfg_data[4:0];
                REG_DRAW_COUNT: dcfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective counts, clamped to 1..max.
    logic [HB:0] h_used;
    logic [CB-1:0] d_used;
    always_comb
    begin
        if (hcfg_reg == 5'd0) h_used = (HB+1)'(1);
        else if (32'(hcfg_reg) > MAX_HYPOTHESES) h_used = (HB+1)'(MAX_HYPOTHESES);
        else h_used = (HB+1)'(hcfg_reg);
        if (dcfg_reg == 11'd0) d_used = CB'(1);
        else if (32'(dcfg_reg) > MAX_DRAWS) d_used = CB'(MAX_DRAWS);
        else d_used = CB'(dcfg_reg);
    end

    // Load decode with saturation and range checks.
    logic acc_in;
    logic [STAT_BITS-1:0] sat_val;
    logic hyp_ok, drw_ok;
    assign acc_in = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    always_comb
    begin
        if (64'(in_data.stat_value) > 64'(STAT_MAX)) sat_val = STAT_MAX;
        else sat_val = STAT_BITS'(in_data.stat_value);
        hyp_ok = 32'(in_data.hyp_index) < MAX_HYPOTHESES;
        drw_ok = 32'(in_data.draw_index) < MAX_DRAWS;
    end

    // Sequencer registers.
    logic [HB-1:0] rank_reg [MAX_HYPOTHESES];
    logic [CB-1:0] cnt_reg [MAX_HYPOTHESES];
    logic [HB:0]   i_reg, j_reg;
    logic [CB-1:0] b_reg;
    logic [STAT_BITS-1:0] run_reg;
    logic [CB-1:0] num_reg [MAX_HYPOTHESES];
    logic [CB-1:0] prev_reg;
    logic [HB:0]   o_reg;

    // Observed RAM: port read by the sort (obs[i]); draw compare reads u_thr.
    logic [HB-1:0] obs_ra;
    logic [STAT_BITS-1:0] obs_rd;
    logic obs_we;
    logic [HB-1:0] obs_wa;
    assign obs_we = acc_in && hyp_ok && (in_data.op == OP_OBSERVED);
    assign obs_wa = HB'(in_data.hyp_index);

    smsp_ram #(.WIDTH(STAT_BITS), .DEPTH(MAX_HYPOTHESES)) u_obs (
        .clk(clk), .wr_en(obs_we), .wr_addr(obs_wa), .wr_data(sat_val),
        .rd_addr(obs_ra), .rd_data(obs_rd));

    // Second observed copy so a sort step reads obs[i] and obs[rank[j-1]] at once.
    logic [HB-1:0] thr_ra;
    logic [STAT_BITS-1:0] thr_rd;
    smsp_ram #(.WIDTH(STAT_BITS), .DEPTH(MAX_HYPOTHESES)) u_thr (
        .clk(clk), .wr_en(obs_we), .wr_addr(obs_wa), .wr_data(sat_val),
        .rd_addr(thr_ra), .rd_data(thr_rd));

    logic rep_we;
    logic [RAB-1:0] rep_wa, rep_ra;
    logic [STAT_BITS-1:0] rep_rd;
    assign rep_we = acc_in && hyp_ok && drw_ok && (in_data.op == OP_BOOTSTRAP);
    assign rep_wa = {HB'(in_data.hyp_index), DB'(in_data.draw_index)};

    smsp_ram #(.WIDTH(STAT_BITS), .DEPTH(MAX_HYPOTHESES * (2 ** DB))) u_rep (
        .clk(clk), .wr_en(rep_we), .wr_addr(rep_wa), .wr_data(sat_val),
        .rd_addr(rep_ra), .rd_data(rep_rd));

    // Read addresses. Sort: reads obs[i] (u_obs) and obs[rank[j-1]] (u_thr).
    logic [HB-1:0] rk_sel;
    assign rk_sel = rank_reg[HB'(j_reg - (HB+1)'(1))];
    always_comb
    begin
        obs_ra = HB'(i_reg);
        thr_ra = rk_sel;
        rep_ra = {rank_reg[HB'(j_reg - (HB+1)'(1))], DB'(b_reg)};
        if (state_reg == S_BRD || state_reg == S_BCMP)
        begin
            thr_ra = rk_sel;
        end
    end

    logic [STAT_BITS-1:0] run_new;
    assign run_new = (rep_rd > run_reg) ? rep_rd : run_reg;

    // Main sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg <= '0;
            j_reg <= '0;
            b_reg <= '0;
            o_reg <= '0;
            for (int k = 0; k < MAX_HYPOTHESES; k++)
            begin
                rank_reg[k] <= '0;
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc_in && in_data.last_load)
                    begin
                        i_reg <= '0;
                    end
                end
                S_SINIT:
                begin
                    // Start inserting element i at position j = i.
                    j_reg <= i_reg;
                end
                S_SRD: ;
                S_SCMP:
                begin
                    // obs_rd = obs[i], thr_rd = obs[rank[j-1]].
                    if (j_reg != '0 && thr_rd < obs_rd)
                    begin
                        rank_reg[HB'(j_reg)] <= rk_sel;
                        j_reg <= j_reg - (HB+1)'(1);
                    end
                    else
                    begin
                        rank_reg[HB'(j_reg)] <= HB'(i_reg);
                        if (i_reg + (HB+1)'(1) == h_used)
                        begin
                            b_reg <= '0;
                            j_reg <= h_used;
                            run_reg <= '0;
                            for (int k = 0; k < MAX_HYPOTHESES; k++)
                            begin
                                cnt_reg[k] <= '0;
                            end
                        end
                        else
                        begin
                            i_reg <= i_reg + (HB+1)'(1);
                        end
                    end
                end
                S_BRD: ;
                S_BCMP:
                begin
                    // rep_rd and thr_rd belong to rank r = j-1.
                    run_reg <= run_new;
                    if (run_new >= thr_rd)
                    begin
                        cnt_reg[HB'(j_reg - (HB+1)'(1))] <=
                            cnt_reg[HB'(j_reg - (HB+1)'(1))] + CB'(1);
                    end
                    if (j_reg == (HB+1)'(1))
                    begin
                        j_reg <= h_used;
                        run_reg <= '0;
                        b_reg <= b_reg + CB'(1);
                        o_reg <= '0;
                        prev_reg <= '0;
                    end
                    else
                    begin
                        j_reg <= j_reg - (HB+1)'(1);
                    end
                end
                S_ACC:
                begin
                    // Prefix maximum of count plus one along rank order.
                    if (cnt_reg[HB'(o_reg)] + CB'(1) > prev_reg)
                    begin
                        num_reg[rank_reg[HB'(o_reg)]] <= cnt_reg[HB'(o_reg)] + CB'(1);
                        prev_reg <= cnt_reg[HB'(o_reg)] + CB'(1);
                    end
                    else
                    begin
                        num_reg[rank_reg[HB'(o_reg)]] <= prev_reg;
                    end
                    o_reg <= (o_reg + (HB+1)'(1) == h_used) ? '0 : o_reg + (HB+1)'(1);
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        o_reg <= o_reg + (HB+1)'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (acc_in && in_data.last_load) state_next = S_SINIT;
            S_SINIT: state_next = S_SRD;
            S_SRD:   state_next = S_SCMP;
            S_SCMP:
            begin
                if (j_reg != '0 && thr_rd < obs_rd) state_next = S_SRD;
                else if (i_reg + (HB+1)'(1) == h_used) state_next = S_BRD;
                else state_next = S_SINIT;
            end
            S_BRD:   state_next = S_BCMP;
            S_BCMP:
            begin
                if (j_reg == (HB+1)'(1) && b_reg + CB'(1) == d_used) state_next = S_ACC;
                else state_next = S_BRD;
            end
            S_ACC:   if (o_reg + (HB+1)'(1) == h_used) state_next = S_OUT;
            S_OUT:   if (!out_stall && o_reg + (HB+1)'(1) == h_used) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Result request, driven from the held numerator table.
    assign out_valid = (state_reg == S_OUT);
    assign out_data.out_hyp = 4'(o_reg);
    assign out_data.adj_numerator = 11'(num_reg[HB'(o_reg)]);
    assign out_data.out_last = (o_reg + (HB+1)'(1) == h_used);

`include "assert_macros.svh"

    `ASSERT_IMPL(a_no_in_busy, clk, rst_n, state_reg != S_IDLE, in_stall,
        "input accepted while computing")
    `ASSERT_NEXT(a_hold_stall, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_data), "result changed while stalled")
    `ASSERT_IMPL(a_num_pos, clk, rst_n, out_valid, out_data.adj_numerator != 11'd0,
        "zero numerator")

endmodule
